### src/stis_pkg.sv
package stis_pkg;

  localparam int OpW    = 2;
  localparam int ValueW = 32;

  typedef logic [OpW-1:0]           op_t;
  typedef logic signed [ValueW-1:0] data_t;

  // operation codes
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_SEARCH = 2'd1;
  localparam op_t OP_READ   = 2'd2;

  // compare unit result: entry against key
  typedef struct packed {
    logic lt;  // entry < key, signed
    logic eq;  // entry == key
  } cmp_res_t;

endpackage

### src/stis_in_if.sv
interface stis_in_if;
  logic            valid;
  logic            ready;
  stis_pkg::op_t   op;
  stis_pkg::data_t value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

### src/stis_out_if.sv
interface stis_out_if #(
  parameter int POS_W = 7
);
  logic             valid;
  logic             ready;
  stis_pkg::data_t  element;
  logic [POS_W-1:0] position;
  logic             entry_valid;
  logic             full_error;
  logic             last;

  modport source (output valid, output element, output position, output entry_valid,
                  output full_error, output last, input ready);
  modport sink   (input valid, input element, input position, input entry_valid,
                  input full_error, input last, output ready);
endinterface

### src/stis_ram.sv
module stis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/stis_cmp.sv
module stis_cmp (
  input  stis_pkg::data_t    entry,
  input  stis_pkg::data_t    key,
  output stis_pkg::cmp_res_t res
);

  always_comb begin
    res.lt = (entry < key);
    res.eq = (entry == key);
  end

endmodule

### src/sorted_table_insert_search.sv
// Channel  Dir  Handshake      Payload
// in_ch    in   valid / ready  op, value
// out_ch   out  valid / ready  element, position, entry_valid, full_error, last
//
// One item at a time; in_ch.ready is high only while the sequencer is idle.
// Insert walks the entries from the back, search from the front; read out
// fetches each entry, then delivers it. The table memory has one read port and
// one write port, registered read.
// Reset (rst_n low, synchronous) empties the table; no clearing pass.
// A stalled out_ch holds the sequencer only where it needs the output register.
module sorted_table_insert_search #(
  parameter int DEPTH = 64
) (
  input logic       clk,
  input logic       rst_n,
  stis_in_if.sink   in_ch,
  stis_out_if.source out_ch
);

  localparam int AddrW = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int PosW  = CntW;
  localparam int OutPosW = $bits(out_ch.position);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for an item
  localparam logic [2:0] S_INS   = 3'd1;  // shift entries up from the back
  localparam logic [2:0] S_PUT   = 3'd2;  // write key at the front
  localparam logic [2:0] S_SRCH  = 3'd3;  // scan from the front
  localparam logic [2:0] S_RDOUT = 3'd4;  // stream every entry
  localparam logic [2:0] S_RESP  = 3'd5;  // single result pending

  logic [2:0]      state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [AddrW-1:0] idx_r, idx_nxt;
  stis_pkg::data_t key_r, key_nxt;
  logic            pend_r, pend_nxt;
  logic [PosW-1:0] resp_pos_r, resp_pos_nxt;
  logic            resp_full_r, resp_full_nxt;

  logic            out_valid_r, out_valid_nxt;
  stis_pkg::data_t out_elem_r, out_elem_nxt;
  logic [PosW-1:0] out_pos_r, out_pos_nxt;
  logic            out_ev_r, out_ev_nxt;
  logic            out_full_r, out_full_nxt;
  logic            out_last_r, out_last_nxt;

  // memory port
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  stis_pkg::data_t  ram_wdata, ram_rdata;

  stis_pkg::cmp_res_t cmp;

  logic in_xfer, out_free, idx_at_end;

  stis_ram #(
    .WIDTH (stis_pkg::ValueW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // one comparator serves insert (ordering) and search (match)
  stis_cmp u_cmp (
    .entry (ram_rdata),
    .key   (key_r),
    .res   (cmp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  // the output register may be loaded this cycle
  assign out_free    = !out_valid_r || out_ch.ready;
  assign idx_at_end  = (CntW'(idx_r) == cnt_r - CntW'(1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    pend_nxt      = pend_r;
    resp_pos_nxt  = resp_pos_r;
    resp_full_nxt = resp_full_r;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_elem_nxt  = out_elem_r;
    out_pos_nxt   = out_pos_r;
    out_ev_nxt    = out_ev_r;
    out_full_nxt  = out_full_r;
    out_last_nxt  = out_last_r;

    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = key_r;
    ram_re    = 1'b0;
    ram_raddr = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          key_nxt       = in_ch.value;
          resp_pos_nxt  = '0;
          resp_full_nxt = 1'b0;
          case (in_ch.op)
            stis_pkg::OP_INSERT: begin
              if (cnt_r == CntW'(DEPTH)) begin
                // refuse: table full, leave it as it is
                resp_full_nxt = 1'b1;
                state_nxt     = S_RESP;
              end else if (cnt_r == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = in_ch.value;
                cnt_nxt   = cnt_r + CntW'(1);
                state_nxt = S_RESP;
              end else begin
                // fetch the last entry and walk towards the front
                ram_re    = 1'b1;
                ram_raddr = AddrW'(cnt_r - CntW'(1));
                idx_nxt   = AddrW'(cnt_r - CntW'(1));
                state_nxt = S_INS;
              end
            end
            stis_pkg::OP_SEARCH: begin
              if (cnt_r == '0) begin
                state_nxt = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_nxt   = '0;
                state_nxt = S_SRCH;
              end
            end
            stis_pkg::OP_READ: begin
              if (cnt_r == '0) begin
                state_nxt = S_RESP;
              end else begin
                idx_nxt   = '0;
                pend_nxt  = 1'b0;
                state_nxt = S_RDOUT;
              end
            end
            default: begin
              // unused code: drop the item
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_INS: begin
        // entry at idx_r is on ram_rdata; it moves up if smaller than key
        ram_we    = 1'b1;
        ram_waddr = idx_r + AddrW'(1);
        if (cmp.lt) begin
          ram_wdata = ram_rdata;
          if (idx_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r - AddrW'(1);
            idx_nxt   = idx_r - AddrW'(1);
          end
        end else begin
          ram_wdata = key_r;
          cnt_nxt   = cnt_r + CntW'(1);
          state_nxt = S_RESP;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = key_r;
        cnt_nxt   = cnt_r + CntW'(1);
        state_nxt = S_RESP;
      end

      S_SRCH: begin
        if (cmp.eq) begin
          resp_pos_nxt = PosW'(idx_r) + PosW'(1);
          state_nxt    = S_RESP;
        end else if (idx_at_end) begin
          state_nxt = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_r + AddrW'(1);
          idx_nxt   = idx_r + AddrW'(1);
        end
      end

      S_RDOUT: begin
        if (pend_r) begin
          // data lands in the output register, which is empty by now
          pend_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          out_elem_nxt  = ram_rdata;
          out_pos_nxt   = PosW'(idx_r) + PosW'(1);
          out_ev_nxt    = 1'b1;
          out_full_nxt  = 1'b0;
          out_last_nxt  = idx_at_end;
          if (idx_at_end) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + AddrW'(1);
          end
        end else if (out_free) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r;
          pend_nxt  = 1'b1;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_elem_nxt  = '0;
          out_pos_nxt   = resp_pos_r;
          out_ev_nxt    = 1'b0;
          out_full_nxt  = resp_full_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    key_r       <= key_nxt;
    resp_pos_r  <= resp_pos_nxt;
    resp_full_r <= resp_full_nxt;
    out_elem_r  <= out_elem_nxt;
    out_pos_r   <= out_pos_nxt;
    out_ev_r    <= out_ev_nxt;
    out_full_r  <= out_full_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.element     = out_elem_r;
  assign out_ch.position    = OutPosW'(out_pos_r);
  assign out_ch.entry_valid = out_ev_r;
  assign out_ch.full_error  = out_full_r;
  assign out_ch.last        = out_last_r;

`ifndef SYNTHESIS
  // the fill count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(DEPTH))
    else $error("entry count beyond table depth");

  // the fill count only ever grows by one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(cnt_r)) |-> (cnt_r == $past(cnt_r) + CntW'(1)))
    else $error("entry count moved by other than one");

  // a refused insert is only reported against a full table
  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |-> (cnt_r == CntW'(DEPTH)))
    else $error("full error with room in the table");

  // results without last come only from a read out in progress
  a_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == S_RDOUT))
    else $error("non-final result outside read out");
`endif

endmodule
